@@ design/wrms_pkg.sv @@
// Shared types and constants for the windowed RMS envelope core.
// Used by wrms_ctrl, wrms_datapath and windowed_rms_envelope_core; no dependencies.
package wrms_pkg;

  // Default field widths and reset window length
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WINDOW_BITS_DEF = 16;
  localparam int RMS_BITS        = 16;
  localparam int WINDOW_RESET    = 480;

  // Sum of squares width: exact for any window, capped at 64 bits (wraps there)
  function automatic int sum_width(input int sample_bits, input int window_bits);
    int w;
    begin
      w = 2 * sample_bits - 1 + window_bits;
      sum_width = (w > 64) ? 64 : w;
    end
  endfunction

  // Controller states
  typedef enum logic [2:0] {
    ST_TAKE,
    ST_FINISH,
    ST_DIV,
    ST_RLOAD,
    ST_ROOT,
    ST_EMIT
  } wrms_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic div_step;
    logic root_init;
    logic root_step;
    logic load_out;
  } wrms_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic complete;
    logic out_free;
  } wrms_stat_t;

endpackage

@@ design/wrms_ctrl.sv @@
// Controller for the windowed RMS envelope core: sequences accumulate, divide,
// square root and result hand-off. Depends on wrms_pkg.
module wrms_ctrl #(
  parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_BITS = wrms_pkg::WINDOW_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  wrms_pkg::wrms_stat_t stat,
  output wrms_pkg::wrms_cmd_t  cmd
);

  localparam int SUM_BITS  = wrms_pkg::sum_width(SAMPLE_BITS, WINDOW_BITS);
  localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
  localparam int STEP_BITS = $clog2(SUM_BITS);

  wrms_pkg::wrms_state_t state, state_next;
  logic [STEP_BITS-1:0]  step, step_next;

  // State and step counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wrms_pkg::ST_TAKE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    case (state)
      wrms_pkg::ST_TAKE: begin
        cmd.take = 1'b1;
        if (in_valid && stat.complete) begin
          state_next = wrms_pkg::ST_FINISH;
        end
      end
      wrms_pkg::ST_FINISH: begin
        // last square lands in the dividend this cycle
        step_next  = '0;
        state_next = wrms_pkg::ST_DIV;
      end
      wrms_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_BITS'(1);
        if (step == STEP_BITS'(SUM_BITS - 1)) begin
          state_next = wrms_pkg::ST_RLOAD;
        end
      end
      wrms_pkg::ST_RLOAD: begin
        cmd.root_init = 1'b1;
        step_next     = '0;
        state_next    = wrms_pkg::ST_ROOT;
      end
      wrms_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        step_next     = step + STEP_BITS'(1);
        if (step == STEP_BITS'(ROOT_BITS - 1)) begin
          state_next = wrms_pkg::ST_EMIT;
        end
      end
      wrms_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = wrms_pkg::ST_TAKE;
        end
      end
      default: begin
        state_next = wrms_pkg::ST_TAKE;
      end
    endcase
  end

endmodule

@@ design/wrms_datapath.sv @@
// Datapath of the windowed RMS envelope core: window length register, squarer,
// accumulator, restoring divider, digit-by-digit square root, output register.
// Depends on wrms_pkg.
module wrms_datapath #(
  parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_BITS = wrms_pkg::WINDOW_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          start_of_signal,
  input  logic                          in_valid,
  input  logic [15:0]                   window_length,
  input  logic                          cfg_valid,
  input  logic                          out_ready,
  output logic [wrms_pkg::RMS_BITS-1:0] rms_value,
  output logic                          out_valid,
  input  wrms_pkg::wrms_cmd_t           cmd,
  output wrms_pkg::wrms_stat_t          stat
);

  localparam int SUM_BITS  = wrms_pkg::sum_width(SAMPLE_BITS, WINDOW_BITS);
  localparam int CNT_BITS  = WINDOW_BITS + 1;
  localparam int SQ_BITS   = 2 * SAMPLE_BITS;
  localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int RMS_W     = wrms_pkg::RMS_BITS;

  logic [WINDOW_BITS-1:0] wlen;
  logic [CNT_BITS-1:0]    count;
  logic [CNT_BITS-1:0]    divisor;
  logic [SQ_BITS-1:0]     sq;
  logic                   sq_valid;
  logic                   sq_start;
  logic                   sq_complete;
  logic [SUM_BITS-1:0]    sum;
  logic [SUM_BITS-1:0]    quot;
  logic [CNT_BITS-1:0]    rem;
  logic [RAD_BITS-1:0]    rad;
  logic [ROOT_BITS-1:0]   root;
  logic [ROOT_BITS:0]     rrem;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  logic [CNT_BITS-1:0]    len;
  logic [CNT_BITS-1:0]    cnt_inc;
  logic [SUM_BITS-1:0]    sum_total;
  logic [CNT_BITS:0]      dtrial;
  logic [CNT_BITS:0]      ddiff;
  logic                   dge;
  logic [ROOT_BITS+2:0]   rtrial;
  logic [ROOT_BITS+2:0]   rsub;
  logic [ROOT_BITS+2:0]   rdiff;
  logic                   rge;

  // Front end: magnitude, window count, completion
  always_comb begin
    accept  = in_valid & cmd.take;
    raw     = sample;
    mag     = raw[SAMPLE_BITS-1] ? ((~raw) + SAMPLE_BITS'(1)) : raw;
    len     = (wlen == '0) ? CNT_BITS'(1) : {1'b0, wlen};
    cnt_inc = (start_of_signal ? '0 : count) + CNT_BITS'(1);
    stat.complete = (cnt_inc >= len);
    stat.out_free = ~out_valid | out_ready;
  end

  // Accumulate, divider step and root step
  always_comb begin
    sum_total = (sq_start ? '0 : sum) + SUM_BITS'(sq);
    dtrial    = {rem, quot[SUM_BITS-1]};
    dge       = (dtrial >= {1'b0, divisor});
    ddiff     = dtrial - {1'b0, divisor};
    rtrial    = {rrem, rad[RAD_BITS-1 -: 2]};
    rsub      = {1'b0, root, 2'b01};
    rge       = (rtrial >= rsub);
    rdiff     = rtrial - rsub;
  end

  // Window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      wlen <= WINDOW_BITS'(wrms_pkg::WINDOW_RESET);
    end else if (cfg_valid) begin
      wlen <= WINDOW_BITS'(window_length);
    end
  end

  // Square stage and window count
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      sq_valid    <= 1'b0;
      sq_start    <= 1'b0;
      sq_complete <= 1'b0;
    end else begin
      sq_valid <= accept;
      if (accept) begin
        sq_start    <= start_of_signal;
        sq_complete <= stat.complete;
        count       <= stat.complete ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq <= mag * mag;
      if (stat.complete) begin
        divisor <= cnt_inc;
      end
    end
  end

  // Running sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (sq_valid) begin
      sum <= sq_complete ? '0 : sum_total;
    end
  end

  // Divider: load dividend on window end, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (sq_valid && sq_complete) begin
      quot <= sum_total;
      rem  <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[SUM_BITS-2:0], dge};
      rem  <= dge ? ddiff[CNT_BITS-1:0] : dtrial[CNT_BITS-1:0];
    end
  end

  // Square root: one result bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad  <= RAD_BITS'(quot);
      root <= '0;
      rrem <= '0;
    end else if (cmd.root_step) begin
      rad  <= rad << 2;
      root <= {root[ROOT_BITS-2:0], rge};
      rrem <= rge ? rdiff[ROOT_BITS:0] : rtrial[ROOT_BITS:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rms_value <= RMS_W'(root);
    end
  end

endmodule

@@ design/windowed_rms_envelope_core.sv @@
// Top level of the windowed RMS envelope core: controller plus datapath.
// Depends on wrms_pkg, wrms_ctrl and wrms_datapath.
//
// Samples are taken one per cycle while a window fills. After the sample that
// closes a window, no sample is taken while the controller runs FINISH, the
// bit-serial divide over SUM = min(2*SAMPLE_BITS-1+WINDOW_BITS, 64) quotient
// bits, RLOAD, the square root over ROOT = ceil(SUM/2) result bits and EMIT,
// which waits for a previous result still in the output register. Samples
// keep flowing while that result waits to be taken. A start_of_signal sample
// drops the partial window. window_length 0 acts as 1; writes are taken at
// any time but belong between windows when the block is idle.
module windowed_rms_envelope_core #(
  parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_BITS = wrms_pkg::WINDOW_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          start_of_signal,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic [wrms_pkg::RMS_BITS-1:0] rms_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic [15:0]                   window_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready
);

  wrms_pkg::wrms_cmd_t  cmd;
  wrms_pkg::wrms_stat_t stat;

  assign in_ready  = cmd.take;
  assign cfg_ready = 1'b1;

  wrms_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .WINDOW_BITS(WINDOW_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  wrms_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .WINDOW_BITS(WINDOW_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .sample          (sample),
    .start_of_signal (start_of_signal),
    .in_valid        (in_valid),
    .window_length   (window_length),
    .cfg_valid       (cfg_valid),
    .out_ready       (out_ready),
    .rms_value       (rms_value),
    .out_valid       (out_valid),
    .cmd             (cmd),
    .stat            (stat)
  );

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while pending");

  // Hold off samples once a window closes
  a_stall_after_close: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && stat.complete) |=> !in_ready)
    else $error("sample taken while window result is in progress");

  // Divider and root never run while samples are taken
  a_backend_exclusive: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step || cmd.root_step || cmd.root_init) |-> !in_ready)
    else $error("back end active while accepting samples");

endmodule
